// ===== design/dmps_pkg.sv =====
// shared types, widths and helpers for the diamond path sum block
package dmps_pkg;

    localparam int CellW = 16;
    localparam int SumW  = 24;
    localparam int CfgW  = 8;

    localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

    typedef struct packed {
        logic widen;
        logic first_row;
        logic up_ok;
        logic left_ok;
        logic last;
    } t_cell_ctrl;

    function automatic logic [SumW-1:0] max_sum(input logic [SumW-1:0] a,
                                                 input logic [SumW-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== design/diamond_max_path_sum.sv =====
// top level of the diamond maximum path sum block
//
//  channel   direction  handshake                        content
//  config    in         i_cfg_valid / o_cfg_ready        diamond side, 8 bits
//  s_axis    in         s_axis_tvalid / s_axis_tready    cell value, 16 bits
//  m_axis    out        m_axis_tvalid / m_axis_tready    path sum, 24 bits
//
// one cell item per cycle unless a last cell stalls; a cell is registered with its line
// reads, then added and written back, and the last cell's sum sits in the output register
// the line ram's single write port and registered read set the cell stage
// reset gives side 1 with no clearing pass; config is always ready and restarts the diamond
// a stalled result holds only the last cell of a diamond, other cells keep flowing
module diamond_max_path_sum #(
    parameter int MAX_SIDE = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [dmps_pkg::CfgW-1:0]  i_cfg_data,      // diamond_side
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,    // cell_value
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata     // path_sum
);
    import dmps_pkg::*;

    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    logic            cfg_wr;
    logic            s_accept;
    t_cell_ctrl      ctrl;
    logic [AW-1:0]   rd_addr0;
    logic [AW-1:0]   rd_addr1;
    logic [SumW-1:0] rd_data0;
    logic [SumW-1:0] rd_data1;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [SumW-1:0] wr_data;
    logic            in_ready;

    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid;
    assign s_axis_tready = in_ready;
    assign s_accept      = s_axis_tvalid && in_ready;

    dmps_ctrl #(
        .MAX_SIDE (MAX_SIDE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_data (i_cfg_data),
        .i_accept   (s_accept),
        .o_ctrl     (ctrl),
        .o_rd_addr0 (rd_addr0),
        .o_rd_addr1 (rd_addr1)
    );

    dmps_ram #(
        .WIDTH (SumW),
        .DEPTH (MAX_SIDE)
    ) u_line (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_en    (s_accept),
        .i_rd_addr0 (rd_addr0),
        .i_rd_addr1 (rd_addr1),
        .o_rd_data0 (rd_data0),
        .o_rd_data1 (rd_data1)
    );

    dmps_cell #(
        .AW (AW)
    ) u_cell (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_accept),
        .i_ctrl      (ctrl),
        .i_addr      (rd_addr0),
        .i_rd_addr0  (rd_addr0),
        .i_rd_addr1  (rd_addr1),
        .i_value     (s_axis_tdata),
        .i_rd_data0  (rd_data0),
        .i_rd_data1  (rd_data1),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (in_ready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== design/dmps_ram.sv =====
// generic simple dual-read ram with one write port and registered reads
module dmps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr0,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr1,
    output logic [WIDTH-1:0]                          o_rd_data0,
    output logic [WIDTH-1:0]                          o_rd_data1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data0;
    logic [WIDTH-1:0] r_rd_data1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data0 <= r_mem[i_rd_addr0];
            r_rd_data1 <= r_mem[i_rd_addr1];
        end
    end

    assign o_rd_data0 = r_rd_data0;
    assign o_rd_data1 = r_rd_data1;

endmodule

// ===== design/dmps_ctrl.sv =====
// row and column tracking, side register and per-cell control
module dmps_ctrl #(
    parameter int MAX_SIDE = 128
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_wr,
    input  logic [dmps_pkg::CfgW-1:0]                    i_cfg_data,
    input  logic                                         i_accept,
    output dmps_pkg::t_cell_ctrl                         o_ctrl,
    output logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] o_rd_addr0,
    output logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] o_rd_addr1
);
    import dmps_pkg::*;

    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int RW = $clog2(2 * MAX_SIDE);
    localparam int CW = RW + 1;

    logic [RW-1:0] r_side;
    logic [RW-1:0] r_last_row;
    logic [RW-1:0] r_row;
    logic [AW-1:0] r_col;

    logic [RW-1:0] side_cfg;
    logic [CW-1:0] last_row_cfg;
    logic [CW-1:0] col_x;
    logic [CW-1:0] row_x;
    logic          row_end;
    t_cell_ctrl    ctrl;

    // zero acts as one, anything above the bound acts as the bound
    always_comb begin
        if (i_cfg_data == '0) begin
            side_cfg = RW'(1);
        end else if (int'(i_cfg_data) > MAX_SIDE) begin
            side_cfg = RW'(MAX_SIDE);
        end else begin
            side_cfg = RW'(i_cfg_data);
        end
        last_row_cfg = {side_cfg, 1'b0} - CW'(2);
    end

    always_comb begin
        col_x          = CW'(r_col);
        row_x          = CW'(r_row);
        ctrl.widen     = r_row < r_side;
        ctrl.first_row = r_row == '0;
        ctrl.up_ok     = col_x < row_x;
        ctrl.left_ok   = r_col != '0;
        if (ctrl.widen) begin
            row_end = col_x == row_x;
        end else begin
            row_end = (col_x + row_x) == CW'(r_last_row);
        end
        ctrl.last = row_end && (r_row == r_last_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= RW'(1);
            r_last_row <= '0;
            r_row      <= '0;
            r_col      <= '0;
        end else if (i_cfg_wr) begin
            r_side     <= side_cfg;
            r_last_row <= RW'(last_row_cfg);
            r_row      <= '0;
            r_col      <= '0;
        end else if (i_accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= ctrl.last ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    assign o_ctrl     = ctrl;
    assign o_rd_addr0 = r_col;
    assign o_rd_addr1 = r_col + 1'b1;

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= r_last_row)
        else $error("row index past last row");

    a_col_in_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row < r_side) |-> (CW'(r_col) <= CW'(r_row)))
        else $error("column past row width in widening half");

endmodule

// ===== design/dmps_cell.sv =====
// cell stage: neighbour select, saturating add, line write and result register
module dmps_cell #(
    parameter int AW = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  dmps_pkg::t_cell_ctrl       i_ctrl,
    input  logic [AW-1:0]              i_addr,
    input  logic [AW-1:0]              i_rd_addr0,
    input  logic [AW-1:0]              i_rd_addr1,
    input  logic [dmps_pkg::CellW-1:0] i_value,
    input  logic [dmps_pkg::SumW-1:0]  i_rd_data0,
    input  logic [dmps_pkg::SumW-1:0]  i_rd_data1,
    input  logic                       i_out_ready,
    output logic                       o_in_ready,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output logic [dmps_pkg::SumW-1:0]  o_wr_data,
    output logic                       o_out_valid,
    output logic [dmps_pkg::SumW-1:0]  o_out_data
);
    import dmps_pkg::*;

    logic             r_a_valid;
    t_cell_ctrl       r_a_ctrl;
    logic [AW-1:0]    r_a_addr;
    logic [CellW-1:0] r_a_value;
    logic             r_byp0;
    logic             r_byp1;
    logic [SumW-1:0]  r_byp_data;
    logic [SumW-1:0]  r_held;
    logic             r_out_valid;
    logic [SumW-1:0]  r_out_data;

    logic            a_fire;
    logic [SumW-1:0] up0;
    logic [SumW-1:0] up1;
    logic [SumW-1:0] prior;
    logic [SumW:0]   sum_wide;
    logic [SumW-1:0] sum;

    assign a_fire     = r_a_valid && (!r_a_ctrl.last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || a_fire;

    // same-cycle write forwarding for the line reads
    assign up0 = r_byp0 ? r_byp_data : i_rd_data0;
    assign up1 = r_byp1 ? r_byp_data : i_rd_data1;

    always_comb begin
        if (r_a_ctrl.widen) begin
            if (r_a_ctrl.first_row) begin
                prior = '0;
            end else begin
                prior = max_sum(r_a_ctrl.up_ok ? up0 : '0, r_a_ctrl.left_ok ? r_held : '0);
            end
        end else begin
            prior = max_sum(up0, up1);
        end
        sum_wide = {1'b0, SumW'(r_a_value)} + {1'b0, prior};
        sum      = sum_wide[SumW] ? SumMax : sum_wide[SumW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_a_valid <= 1'b1;
            end else if (a_fire) begin
                r_a_valid <= 1'b0;
            end
            if (a_fire && r_a_ctrl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_ctrl   <= i_ctrl;
            r_a_addr   <= i_addr;
            r_a_value  <= i_value;
            r_byp0     <= a_fire && (r_a_addr == i_rd_addr0);
            r_byp1     <= a_fire && (r_a_addr == i_rd_addr1);
            r_byp_data <= sum;
        end
        if (a_fire) begin
            r_held <= up0;
        end
        if (a_fire && r_a_ctrl.last) begin
            r_out_data <= sum;
        end
    end

    assign o_wr_en     = a_fire;
    assign o_wr_addr   = r_a_addr;
    assign o_wr_data   = sum;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_a_valid && r_a_ctrl.last))
        else $error("result raised without a last cell");

    a_first_row_widens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_ctrl.first_row) |-> r_a_ctrl.widen)
        else $error("first row outside widening half");

endmodule

// ===== tb/dmps_path_checker.sv =====
// channel monitor, path sum predictor and result checker for diamond_max_path_sum
module dmps_path_checker #(
    parameter int MAX_SIDE = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [dmps_pkg::CfgW-1:0]  i_cfg_data,
    input  logic                       i_cell_valid,
    input  logic                       i_cell_ready,
    input  logic [dmps_pkg::CellW-1:0] i_cell_data,
    input  logic                       i_sum_valid,
    input  logic                       i_sum_ready,
    input  logic [dmps_pkg::SumW-1:0]  i_sum_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dmps_pkg::*;

    logic [SumW-1:0] line_best [MAX_SIDE];
    logic [SumW-1:0] left_best;
    logic [CfgW-1:0] side_reg;
    int unsigned     cur_row;
    int unsigned     cur_col;
    logic [SumW-1:0] sums_due[$];
    int              fails = 0;
    bit              diamond_done;
    logic [SumW-1:0] new_sum;
    logic [SumW-1:0] want_sum;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic accumulate_cell(input logic [CellW-1:0] value, output bit last_cell,
                                   output logic [SumW-1:0] total);
        int unsigned n;
        int unsigned width;
        int unsigned above;
        int unsigned beside;
        int unsigned prior;
        int unsigned raw;
        n = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
        prior = 0;
        if (cur_row < n) begin
            // widening half: upper-left is held, upper sits at this column
            width = cur_row + 1;
            if (cur_row > 0) begin
                above  = (cur_col < cur_row) ? line_best[cur_col] : 0;
                beside = (cur_col > 0) ? left_best : 0;
                prior  = (above > beside) ? above : beside;
            end
            left_best = line_best[cur_col];
        end else begin
            // narrowing half: upper and upper-right
            width  = 2 * n - 1 - cur_row;
            above  = line_best[cur_col];
            beside = line_best[(cur_col + 1) % MAX_SIDE];
            prior  = (above > beside) ? above : beside;
        end
        raw = value + prior;
        total = (raw > SumMax) ? SumMax : raw[SumW-1:0];
        line_best[cur_col] = total;
        last_cell = 1'b0;
        cur_col++;
        if (cur_col >= width) begin
            cur_col   = 0;
            cur_row++;
            left_best = '0;
            if (cur_row >= 2 * n - 1) begin
                cur_row   = 0;
                last_cell = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SIDE; i++) line_best[i] = '0;
            left_best = '0;
            side_reg  = 8'd1;
            cur_row   = 0;
            cur_col   = 0;
            sums_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                // a new side abandons the diamond in progress
                side_reg  = i_cfg_data;
                left_best = '0;
                cur_row   = 0;
                cur_col   = 0;
            end
            if (i_cell_valid && i_cell_ready) begin
                accumulate_cell(i_cell_data, diamond_done, new_sum);
                if (diamond_done) sums_due.push_back(new_sum);
            end
            if (i_sum_valid && i_sum_ready) begin
                if (sums_due.size() == 0) begin
                    fails++;
                    $display("%0t ns: path_sum expected none, got %0d", $time, i_sum_data);
                end else begin
                    want_sum = sums_due.pop_front();
                    if (i_sum_data !== want_sum) begin
                        fails++;
                        $display("%0t ns: path_sum expected %0d, got %0d",
                                 $time, want_sum, i_sum_data);
                    end
                end
            end
        end
        o_pending    <= sums_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/tb_diamond_max_path_sum.sv =====
// stimulus, flow control and verdict for the diamond maximum path sum block
module tb_diamond_max_path_sum;
    timeunit 1ns;
    timeprecision 1ps;

    import dmps_pkg::*;

    localparam int MaxSide       = 128;
    localparam int WatchdogLimit = 5000;
    localparam int HoldCycles    = 300;
    localparam int SettleCycles  = 8;
    localparam int PhaseItems    = 110;
    localparam int WideCells     = 20;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [CfgW-1:0]   i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [CellW-1:0]  s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [SumW-1:0]   m_axis_tdata;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_token     = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int cells_sent     = 0;
    int cur_side       = 1;

    logic [CellW-1:0] side3_cells [9] = '{16'd7, 16'hFFFF, 16'd3, 16'd0, 16'd0,
                                          16'hFFFF, 16'd5, 16'hFFFF, 16'd1};

    diamond_max_path_sum #(
        .MAX_SIDE(MaxSide)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),     // cell_value
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)      // path_sum
    );

    dmps_path_checker #(
        .MAX_SIDE(MaxSide)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_cell_valid (s_axis_tvalid),
        .i_cell_ready (s_axis_tready),
        .i_cell_data  (s_axis_tdata),
        .i_sum_valid  (m_axis_tvalid),
        .i_sum_ready  (m_axis_tready),
        .i_sum_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stalls plus a long hold-off each time hold_token is bumped
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [CellW-1:0] rand_cell();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return CellW'($urandom_range(15));
            default: return CellW'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_cell(input logic [CellW-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        cells_sent++;
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_side(input int side);
        wait_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CfgW'(side);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_side = (side == 0) ? 1 : ((side > MaxSide) ? MaxSide : side);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
        int start;
        int reps;
        int ncells;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = cells_sent;
        while (cells_sent - start < items) begin
            pick = $urandom_range(19);
            if (pick == 0)      write_side(0);
            else if (pick == 1) write_side($urandom_range(7, 12));
            else                write_side($urandom_range(1, 6));
            reps = $urandom_range(1, 3);
            for (int d = 0; d < reps; d++) begin
                ncells = cur_side * cur_side;
                // broken diamond: cut short, the next side write abandons it
                if ($urandom_range(7) == 0) begin
                    ncells = $urandom_range(ncells - 1);
                    d = reps;
                end
                for (int k = 0; k < ncells; k++) send_cell(rand_cell());
                if ($urandom_range(9) == 0) wait_results();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: side after reset, side zero, small diamonds
        send_cell('0);
        send_cell('1);
        write_side(0);
        send_cell(16'h8001);
        write_side(2);
        send_cell(16'd1);
        send_cell(16'hFFFF);
        send_cell(16'd0);
        send_cell(16'hFFFF);
        send_cell(16'd1);
        send_cell(16'd0);
        send_cell(16'hFFFF);
        send_cell(16'hFFFF);
        write_side(3);
        for (int k = 0; k < 9; k++) send_cell(side3_cells[k]);

        // widest side, top rows at full scale, abandoned by the next side write
        write_side(MaxSide);
        for (int k = 0; k < WideCells; k++) send_cell('1);

        run_phase(0, 0, PhaseItems);
        run_phase(45, 0, PhaseItems);
        run_phase(0, 45, PhaseItems);
        run_phase(37, 37, PhaseItems);

        // long result hold-off while cells are still offered
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_side(1);
        hold_token++;
        for (int k = 0; k < 40; k++) send_cell(rand_cell());

        // side above the bound acts as the bound
        send_idle_pct  = 37;
        recv_stall_pct = 37;
        write_side(255);
        for (int k = 0; k < WideCells; k++) send_cell(rand_cell());

        wait_results();
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/dmps_pkg.sv
design/dmps_ram.sv
design/dmps_ctrl.sv
design/dmps_cell.sv
design/diamond_max_path_sum.sv
tb/dmps_path_checker.sv
tb/tb_diamond_max_path_sum.sv
